[src/bsdc_pkg.sv]
// Shared types and constants for the banded step damper controller.
// Used by bsdc_tick and by the top level banded_step_damper_controller.
package bsdc_pkg;

   // Temperature bits ignored when choosing each band.
   localparam logic [7:0] MASK_BAND2 = 8'd3;
   localparam logic [7:0] MASK_BAND3 = 8'd15;
   localparam logic [7:0] MASK_BAND4 = 8'd63;

   localparam logic [7:0] KEEP_BAND2 = ~MASK_BAND2;
   localparam logic [7:0] KEEP_BAND3 = ~MASK_BAND3;
   localparam logic [7:0] KEEP_BAND4 = ~MASK_BAND4;

   localparam int CFG_COUNT = 8;
   localparam int BAND_COUNT = 4;

   // Band codes, nearest to farthest.
   localparam logic [1:0] BAND_1 = 2'd0;
   localparam logic [1:0] BAND_2 = 2'd1;
   localparam logic [1:0] BAND_3 = 2'd2;
   localparam logic [1:0] BAND_4 = 2'd3;

   // Register file halves: waits first, then steps.
   localparam logic REG_WAIT = 1'b0;
   localparam logic REG_STEP = 1'b1;

   // Clamp flag codes.
   localparam logic [1:0] LIMIT_NONE  = 2'd0;
   localparam logic [1:0] LIMIT_OPEN  = 2'd1;
   localparam logic [1:0] LIMIT_CLOSE = 2'd2;

   localparam logic [15:0] POSITION_MAX = 16'hFFFF;

   typedef logic [CFG_COUNT-1:0][15:0] cfg_type;

   typedef struct packed {
      logic [7:0]  stove_temp;
      logic [7:0]  target_temp;
      logic [15:0] open_limit;
      logic [15:0] close_limit;
      logic        load_position;
      logic [15:0] load_value;
   } item_type;

   typedef struct packed {
      logic [15:0] tick_count;
      logic [15:0] active_wait;
      logic [15:0] active_step;
      logic [7:0]  reference_temp;
      logic [15:0] position;
      logic [1:0]  last_limit;
   } state_type;

   typedef struct packed {
      logic [15:0] damper_position;
      logic [1:0]  limit_hit;
      logic        moved;
   } result_type;

endpackage

[src/bsdc_tick.sv]
// Next-state and result logic for one control tick of the damper controller.
// Depends on bsdc_pkg for the item, state, result and register file types.
module bsdc_tick (
   input  bsdc_pkg::cfg_type    cfg,
   input  bsdc_pkg::state_type  state,
   input  bsdc_pkg::item_type   item,
   output bsdc_pkg::state_type  state_next,
   output bsdc_pkg::result_type result
);

   always_comb begin
      logic [15:0] pos;
      logic [1:0]  band;
      logic [15:0] wait_len;
      logic [15:0] step_len;
      logic [15:0] open_pos;
      logic [16:0] close_sum;
      logic [15:0] close_pos;
      logic        moved;

      state_next = state;
      moved = 1'b0;

      pos = item.load_position ? item.load_value : state.position;
      state_next.position = pos;

      if ((item.stove_temp & bsdc_pkg::KEEP_BAND2) == (item.target_temp & bsdc_pkg::KEEP_BAND2)) begin
         band = bsdc_pkg::BAND_1;
      end else if ((item.stove_temp & bsdc_pkg::KEEP_BAND3) ==
                   (item.target_temp & bsdc_pkg::KEEP_BAND3)) begin
         band = bsdc_pkg::BAND_2;
      end else if ((item.stove_temp & bsdc_pkg::KEEP_BAND4) ==
                   (item.target_temp & bsdc_pkg::KEEP_BAND4)) begin
         band = bsdc_pkg::BAND_3;
      end else begin
         band = bsdc_pkg::BAND_4;
      end

      // At the target the previous band choice stays in force.
      if (item.stove_temp != item.target_temp) begin
         wait_len = cfg[{bsdc_pkg::REG_WAIT, band}];
         step_len = cfg[{bsdc_pkg::REG_STEP, band}];
      end else begin
         wait_len = state.active_wait;
         step_len = state.active_step;
      end
      state_next.active_wait = wait_len;
      state_next.active_step = step_len;

      // Open step: saturating subtract, then clamp at the open limit.
      open_pos = (pos >= step_len) ? pos - step_len : 16'd0;
      // Close step: saturating add, then clamp at the close limit.
      close_sum = {1'b0, pos} + {1'b0, step_len};
      close_pos = close_sum[16] ? bsdc_pkg::POSITION_MAX : close_sum[15:0];

      if (state.tick_count <= wait_len) begin
         state_next.tick_count = state.tick_count + 16'd1;
      end else begin
         state_next.tick_count = 16'd0;
         state_next.reference_temp = item.stove_temp;
         if (item.stove_temp < item.target_temp) begin
            if (item.stove_temp <= state.reference_temp) begin
               moved = 1'b1;
               if (open_pos < item.open_limit) begin
                  state_next.position = item.open_limit;
                  state_next.last_limit = bsdc_pkg::LIMIT_OPEN;
               end else begin
                  state_next.position = open_pos;
                  state_next.last_limit = bsdc_pkg::LIMIT_NONE;
               end
            end
         end else begin
            if (item.stove_temp >= state.reference_temp) begin
               moved = 1'b1;
               if (close_pos > item.close_limit) begin
                  state_next.position = item.close_limit;
                  state_next.last_limit = bsdc_pkg::LIMIT_CLOSE;
               end else begin
                  state_next.position = close_pos;
                  state_next.last_limit = bsdc_pkg::LIMIT_NONE;
               end
            end
         end
      end

      result.damper_position = state_next.position;
      result.limit_hit = state_next.last_limit;
      result.moved = moved;
   end

endmodule

[src/banded_step_damper_controller.sv]
// Top level of the banded step damper controller: stream channels, APB register file,
// controller state and the result register. Depends on bsdc_pkg and bsdc_tick.
//
// Each transfer on the req_ channel is one control tick and yields exactly one
// transfer on the rsp_ channel. The tick is evaluated in the cycle the request is
// taken and the result appears on rsp_ in the next cycle. One tick is accepted every
// cycle unless a waiting result is held by rsp_tready low; the single result register
// sets that rate; controller state is updated at the same clock edge that loads it.
// While the receiver holds rsp_tready low and a result is waiting, req_tready is
// low; req_tready returns high in the same cycle the waiting result is taken, so
// a new tick can be taken in the cycle the waiting result drains.
// The eight 16-bit registers (wait_band1..4, step_band1..4) sit at byte addresses
// 0x00 to 0x1C of the csr_ port; write them only while no tick is in flight.
// Reset clears the registers, the tick counter, the band choice, the reference
// temperature, the damper position and the clamp flag, and empties the result
// register.
module banded_step_damper_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] stove_temp, [15:8] target_temp, [31:16] open_limit,
   // [47:32] close_limit, [63:48] load_value
   input  logic [63:0] req_tdata,
   // [0] load_position
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] damper_position, [17:16] limit_hit, [18] moved, [23:19] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bsdc_pkg::cfg_type    cfg_ff, cfg_in;
   bsdc_pkg::state_type  state_ff, state_in;
   bsdc_pkg::item_type   item;
   bsdc_pkg::result_type result;
   bsdc_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_take;
   logic                 csr_write;
   logic [2:0]           csr_index;

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[4:2];
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {16'd0, cfg_ff[csr_index]};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         cfg_in[csr_index] = csr_pwdata[15:0];
      end
   end

   assign item.stove_temp = req_tdata[7:0];
   assign item.target_temp = req_tdata[15:8];
   assign item.open_limit = req_tdata[31:16];
   assign item.close_limit = req_tdata[47:32];
   assign item.load_value = req_tdata[63:48];
   assign item.load_position = req_tuser[0];

   bsdc_tick u_tick (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item),
      .state_next (state_in),
      .result     (result)
   );

   // The result register can take a new tick when empty or being drained.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_take = req_tvalid & req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_in = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_take) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, rsp_ff.moved, rsp_ff.limit_hit, rsp_ff.damper_position};

   // Every accepted tick leaves a result waiting in the next cycle.
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // The reported position is the position the controller keeps.
   a_position_tracks: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_ff.damper_position == state_ff.position)
      else $error("reported position differs from stored position");

   // A move only happens when the tick counter restarts.
   a_move_clears_count: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (!rsp_ff.moved || state_ff.tick_count == 16'd0))
      else $error("move reported without counter restart");

   // The clamp flag only ever holds one of its three codes.
   a_limit_code: assert property (@(posedge clock) disable iff (reset)
      state_ff.last_limit == bsdc_pkg::LIMIT_NONE ||
      state_ff.last_limit == bsdc_pkg::LIMIT_OPEN ||
      state_ff.last_limit == bsdc_pkg::LIMIT_CLOSE)
      else $error("clamp flag holds an unused code");

endmodule
